// ===== rtl/core/bsc_pkg.sv =====
// shared constants, types and command/status structs for the bubble sort core
`default_nettype none

package bsc_pkg;

	localparam int SIZE      = 32;
	localparam int IDX_W     = $clog2(SIZE);
	localparam int CNT_W     = $clog2(SIZE + 1);
	localparam int VAL_W     = 16;
	localparam int POS_W     = 5;
	localparam int SWAP_W    = 9;
	localparam int PAIRS_MAX = SIZE * (SIZE - 1) / 2;
	localparam int SWAP_CAP  = (PAIRS_MAX < 511) ? PAIRS_MAX : 511;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		WR_INPUT,
		WR_CMP,
		WR_CARRY
	} wr_sel_t;

	typedef struct packed {
		logic    mem_we;
		wr_sel_t wr_sel;
		idx_t    wr_addr;
		logic    rd_en;
		idx_t    rd_addr;
		logic    carry_load;
		logic    cmp_step;
		logic    swap_clr;
		logic    out_load;
		idx_t    out_pos;
		logic    out_last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsc_datapath.sv =====
// element memory, carry register, comparator, swap counter and output register
`default_nettype none

module bsc_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire bsc_pkg::cmd_t                 cmd,
	output bsc_pkg::sts_t                      sts,
	input  wire signed [bsc_pkg::VAL_W-1:0]    element_value,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [bsc_pkg::VAL_W-1:0]   sorted_value,
	output logic [bsc_pkg::POS_W-1:0]          position,
	output logic [bsc_pkg::SWAP_W-1:0]         swap_total,
	output logic                               last_flag
);
	import bsc_pkg::*;

	logic signed [VAL_W-1:0] mem [SIZE];
	logic signed [VAL_W-1:0] rd_data_q;
	logic signed [VAL_W-1:0] cur_q;
	logic signed [VAL_W-1:0] wr_data;
	logic [SWAP_W-1:0]       swap_q;
	logic                    gt;

	assign gt = cur_q > rd_data_q;

	always_comb begin
		case (cmd.wr_sel)
			WR_INPUT: wr_data = element_value;
			WR_CMP:   wr_data = gt ? rd_data_q : cur_q;
			WR_CARRY: wr_data = cur_q;
			default:  wr_data = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_addr];
		end
	end

	// the larger value keeps bubbling in the carry register
	always_ff @(posedge clk) begin
		if (cmd.carry_load || (cmd.cmp_step && !gt)) begin
			cur_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= '0;
		end else if (cmd.swap_clr) begin
			swap_q <= '0;
		end else if (cmd.cmp_step && gt && (swap_q < SWAP_W'(SWAP_CAP))) begin
			swap_q <= swap_q + SWAP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sorted_value <= rd_data_q;
			position     <= POS_W'(cmd.out_pos);
			swap_total   <= swap_q;
			last_flag    <= cmd.out_last;
		end
	end

	assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== rtl/core/bsc_ctrl.sv =====
// sequencer for load, bubble passes and ordered read-out
`default_nettype none

module bsc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire bsc_pkg::sts_t   sts,
	output bsc_pkg::cmd_t        cmd
);
	import bsc_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_FIRST,
		ST_PASS_CMP,
		ST_PASS_END,
		ST_EMIT
	} state_t;

	state_t           state_q;
	idx_t             load_q;
	idx_t             top_q;
	idx_t             k_q;
	idx_t             k_inc;
	logic [CNT_W-1:0] iss_q;
	logic             pend_q;
	idx_t             pend_pos_q;
	logic             accept;
	logic             move;
	logic             issue;
	logic             iss_done;

	assign k_inc    = k_q + idx_t'(1);
	assign accept   = in_valid && (state_q == ST_LOAD);
	assign iss_done = (iss_q == CNT_W'(SIZE));
	assign move     = (state_q == ST_EMIT) && pend_q && sts.out_free;
	assign issue    = (state_q == ST_EMIT) && !iss_done && (!pend_q || move);
	assign in_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd            = '0;
		cmd.wr_sel     = WR_INPUT;
		cmd.out_pos    = pend_pos_q;
		cmd.out_last   = (pend_pos_q == idx_t'(SIZE - 1));
		case (state_q)
			ST_LOAD: begin
				cmd.mem_we  = accept;
				cmd.wr_addr = load_q;
				if (accept && (load_q == idx_t'(SIZE - 1))) begin
					cmd.swap_clr = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_addr  = '0;
				end
			end
			ST_PASS_FIRST: begin
				cmd.carry_load = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_addr    = idx_t'(1);
			end
			ST_PASS_CMP: begin
				cmd.cmp_step = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.wr_sel   = WR_CMP;
				cmd.wr_addr  = k_q;
				if (k_inc != top_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = k_inc + idx_t'(1);
				end
			end
			ST_PASS_END: begin
				cmd.mem_we  = 1'b1;
				cmd.wr_sel  = WR_CARRY;
				cmd.wr_addr = top_q;
				if (top_q != idx_t'(1)) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = '0;
				end
			end
			ST_EMIT: begin
				cmd.out_load = move;
				cmd.rd_en    = issue;
				cmd.rd_addr  = iss_q[IDX_W-1:0];
			end
			default: begin
				cmd.wr_addr = load_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_q     <= '0;
			top_q      <= '0;
			k_q        <= '0;
			iss_q      <= '0;
			pend_q     <= 1'b0;
			pend_pos_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (load_q == idx_t'(SIZE - 1)) begin
							load_q  <= '0;
							top_q   <= idx_t'(SIZE - 1);
							state_q <= ST_PASS_FIRST;
						end else begin
							load_q <= load_q + idx_t'(1);
						end
					end
				end
				ST_PASS_FIRST: begin
					k_q     <= '0;
					state_q <= ST_PASS_CMP;
				end
				ST_PASS_CMP: begin
					if (k_inc == top_q) begin
						state_q <= ST_PASS_END;
					end else begin
						k_q <= k_inc;
					end
				end
				ST_PASS_END: begin
					top_q <= top_q - idx_t'(1);
					if (top_q == idx_t'(1)) begin
						iss_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PASS_FIRST;
					end
				end
				ST_EMIT: begin
					// one read in flight at most, handed to the output register when it frees
					if (issue) begin
						pend_q     <= 1'b1;
						pend_pos_q <= iss_q[IDX_W-1:0];
						iss_q      <= iss_q + CNT_W'(1);
					end else if (move) begin
						pend_q <= 1'b0;
						if (iss_done) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bubble_sort_swap_count_core.sv =====
// bubble sort core with swap count: top level joining sequencer and datapath
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  element_value
// out      output     out_valid/out_stall  sorted_value, position, swap_total, last_flag
//
// a block of SIZE items is loaded one per cycle, then sorted by passes over the
// element memory with one comparator: each pass loads the carry register, steps
// the comparator along the pairs below top and writes the carry to entry top
// reset clears the sequencer and counters; the element memory is left as is
// a stalled output holds the read-out; loading of the next block may start
// while the last result still waits in the output register
`default_nettype none

module bubble_sort_swap_count_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire signed [bsc_pkg::VAL_W-1:0]    element_value,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [bsc_pkg::VAL_W-1:0]   sorted_value,
	output logic [bsc_pkg::POS_W-1:0]          position,
	output logic [bsc_pkg::SWAP_W-1:0]         swap_total,
	output logic                               last_flag
);
	import bsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sorted_value  (sorted_value),
		.position      (position),
		.swap_total    (swap_total),
		.last_flag     (last_flag)
	);

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten before it was taken");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mem_we && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
		else $error("memory read and write at the same address");

	a_swap_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (swap_total <= SWAP_W'(SWAP_CAP)))
		else $error("swap total above its cap");

	a_load_vs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !cmd.out_load)
		else $error("item accepted during read-out");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the bubble sort core with swap count: block stimulus, sort prediction, result checks
module tb_top;

	import bsc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 700;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        pos;
		logic [SWAP_W-1:0]       swaps;
		logic                    last;
	} sorted_elem_t;

	typedef enum {
		FILL_RANDOM,
		FILL_ASCENDING,
		FILL_DESCENDING,
		FILL_FEW_VALUES,
		FILL_NEAR_SORTED
	} fill_t;

	class sort_scoreboard;
		logic signed [VAL_W-1:0] block_vals [SIZE];
		int loaded = 0;
		int errors = 0;
		sorted_elem_t sorted_q [$];

		function void note_element(logic signed [VAL_W-1:0] v);
			int top;
			int k;
			int swaps;
			logic signed [VAL_W-1:0] tmp;
			sorted_elem_t e;
			block_vals[loaded] = v;
			loaded++;
			if (loaded == SIZE) begin
				swaps = 0;
				for (top = SIZE - 1; top > 0; top--) begin
					for (k = 0; k < top; k++) begin
						if (block_vals[k] > block_vals[k + 1]) begin
							tmp = block_vals[k];
							block_vals[k] = block_vals[k + 1];
							block_vals[k + 1] = tmp;
							if (swaps < SWAP_CAP)
								swaps++;
						end
					end
				end
				for (k = 0; k < SIZE; k++) begin
					e.value = block_vals[k];
					e.pos = k[POS_W-1:0];
					e.swaps = swaps[SWAP_W-1:0];
					e.last = (k == SIZE - 1);
					sorted_q.push_back(e);
				end
				loaded = 0;
			end
		endfunction

		function void check_result(sorted_elem_t got);
			sorted_elem_t want;
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected item value %0d position %0d swaps %0d last %0d",
					$time, got.value, got.pos, got.swaps, got.last);
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (got.value !== want.value) begin
					$display("%0t: sorted_value expected %0d got %0d", $time, want.value, got.value);
					errors++;
				end
				if (got.pos !== want.pos) begin
					$display("%0t: position expected %0d got %0d", $time, want.pos, got.pos);
					errors++;
				end
				if (got.swaps !== want.swaps) begin
					$display("%0t: swap_total expected %0d got %0d", $time, want.swaps, got.swaps);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last_flag expected %0d got %0d", $time, want.last, got.last);
					errors++;
				end
			end
		endfunction

		function int pending();
			return sorted_q.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [VAL_W-1:0]   element_value;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VAL_W-1:0]   sorted_value;
	logic [POS_W-1:0]          position;
	logic [SWAP_W-1:0]         swap_total;
	logic                      last_flag;

	sort_scoreboard board = new();
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int idle_cycles = 0;

	bubble_sort_swap_count_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sorted_value  (sorted_value),
		.position      (position),
		.swap_total    (swap_total),
		.last_flag     (last_flag)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// valid stays high between back-to-back items; stall is read at the falling edge
	task automatic send_element(input logic signed [VAL_W-1:0] v);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		board.note_element(v);
	endtask

	task automatic receive_result();
		int hold;
		sorted_elem_t got;
		hold = rx_burst ? 0 : $urandom_range(0, 15);
		if (hold > 0) begin
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			out_stall <= 1'b0;
		end
		do @(negedge clk); while (!out_valid);
		got.value = sorted_value;
		got.pos = position;
		got.swaps = swap_total;
		got.last = last_flag;
		@(posedge clk);
		board.check_result(got);
	endtask

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		n = 0;
		forever begin
			receive_result();
			n++;
			if (n % 40 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		logic signed [VAL_W-1:0] vals [SIZE];
		logic signed [VAL_W-1:0] tmp;
		fill_t mode;
		int b;
		int k;
		int acc;
		arst_n = 1'b0;
		in_valid = 1'b0;
		element_value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strictly descending from the top value to the bottom one: every pair swaps
		for (k = 0; k < SIZE - 1; k++)
			send_element(VAL_W'(32767 - k * 2113));
		send_element(-32768);

		for (b = 0; b < 9; b++) begin
			if (b == 0)
				mode = FILL_FEW_VALUES;
			else if (b == 1)
				mode = FILL_ASCENDING;
			else
				mode = fill_t'($urandom_range(0, 4));
			case (mode)
				FILL_RANDOM: begin
					for (k = 0; k < SIZE; k++)
						vals[k] = VAL_W'($urandom);
				end
				FILL_FEW_VALUES: begin
					// many equal neighbours, which must never count as swaps
					for (k = 0; k < SIZE; k++)
						vals[k] = VAL_W'($urandom_range(0, 3) - 2);
				end
				default: begin
					acc = $urandom_range(0, 1000) - 32768;
					for (k = 0; k < SIZE; k++) begin
						vals[(mode == FILL_DESCENDING) ? SIZE - 1 - k : k] = VAL_W'(acc);
						acc += $urandom_range(0, 2000);
					end
					if (mode == FILL_NEAR_SORTED) begin
						k = $urandom_range(0, SIZE - 2);
						tmp = vals[k];
						vals[k] = vals[k + 1];
						vals[k + 1] = tmp;
					end
				end
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			for (k = 0; k < SIZE; k++)
				send_element(vals[k]);
		end

		// an unfinished block must produce nothing
		tx_burst = 1'b0;
		for (k = 0; k < 10; k++)
			send_element(VAL_W'($urandom));
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
